FILE: hdl/ipds_pkg.sv
// Package for the IPv6 destination policy sorter: shared types and constants.
// No dependencies.
package ipds_pkg;
	localparam int ADDR_W = 64;
	localparam int SCOPE_W = 16;
	localparam int KEY_W = 10;
	localparam int MASK_W = 5;
	localparam int RANK_W = 8;
	localparam int PREC_W = 9;
	localparam logic [MASK_W-1:0] MAX_BYTES = 5'd16;
	localparam logic OP_ENTRY = 1'b0;
	localparam logic OP_ADDR = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] hi;
		logic [ADDR_W-1:0] lo;
		logic [SCOPE_W-1:0] scope;
		logic [KEY_W-1:0] key;
	} item_t;

	// 128-bit mask with the first n bytes set, MSB first
	function automatic logic [2*ADDR_W-1:0] byte_mask(input logic [MASK_W-1:0] n);
		logic [2*ADDR_W-1:0] m;
		m = '0;
		for (int b = 0; b < 16; b++) begin
			if (5'(b) < n) m[2*ADDR_W-1-8*b -: 8] = 8'hff;
		end
		return m;
	endfunction
endpackage

FILE: hdl/ipds_cell.sv
// One cell of the sorting chain: holds one list item and hands it on.
// Depends on ipds_pkg.
module ipds_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  logic ins,
	input  ipds_pkg::item_t new_item,
	input  logic prev_valid,
	input  logic prev_lower,
	input  ipds_pkg::item_t prev_item,
	input  logic shift_out,
	input  logic next_valid,
	input  ipds_pkg::item_t next_item,
	output logic valid,
	output logic lower,
	output ipds_pkg::item_t item
);
	logic valid_q;
	logic take;
	ipds_pkg::item_t item_q;
	assign valid = valid_q;
	assign item = item_q;
	// a held item is strictly below the new key: the new item goes ahead of it
	assign lower = !valid_q || (item_q.key < new_item.key);
	// an empty cell fills only when the cell ahead of it holds an item
	assign take = ins && lower && (valid_q || prev_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift_out) begin
			valid_q <= next_valid;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_out) begin
			item_q <= next_item;
		end else if (take) begin
			item_q <= (prev_valid && prev_lower) ? prev_item : new_item;
		end
	end
endmodule

FILE: hdl/ipds_classify.sv
// Policy table and classifier: stores entries and computes the sort key.
// Depends on ipds_pkg.
module ipds_classify #(
	parameter int POLICY_ENTRIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  logic [2:0] wr_index,
	input  logic [ipds_pkg::ADDR_W-1:0] hi,
	input  logic [ipds_pkg::ADDR_W-1:0] lo,
	input  logic [ipds_pkg::SCOPE_W-1:0] scope,
	input  logic [ipds_pkg::MASK_W-1:0] nbytes,
	input  logic [ipds_pkg::RANK_W-1:0] rank,
	input  logic src,
	input  logic en,
	output logic [ipds_pkg::KEY_W-1:0] key
);
	logic [POLICY_ENTRIES-1:0][2*ipds_pkg::ADDR_W-1:0] pfx_q, mask_q;
	logic [POLICY_ENTRIES-1:0][ipds_pkg::SCOPE_W-1:0] scope_q;
	logic [POLICY_ENTRIES-1:0][ipds_pkg::RANK_W-1:0] rank_q;
	logic [POLICY_ENTRIES-1:0] src_q, valid_q, hit;
	logic [ipds_pkg::MASK_W-1:0] nb_sat;

	assign nb_sat = (nbytes > ipds_pkg::MAX_BYTES) ? ipds_pkg::MAX_BYTES : nbytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int e = 0; e < POLICY_ENTRIES; e++) begin
				if (wr && 32'(wr_index) == e) valid_q[e] <= en;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int e = 0; e < POLICY_ENTRIES; e++) begin
			if (wr && 32'(wr_index) == e) begin
				pfx_q[e] <= {hi, lo};
				mask_q[e] <= ipds_pkg::byte_mask(nb_sat);
				scope_q[e] <= scope;
				rank_q[e] <= rank;
				src_q[e] <= src;
			end
		end
	end

	always_comb begin
		for (int e = 0; e < POLICY_ENTRIES; e++) begin
			hit[e] = valid_q[e] && scope_q[e] == scope &&
				((({hi, lo} ^ pfx_q[e]) & mask_q[e]) == '0);
		end
		key = '0;
		for (int e = POLICY_ENTRIES - 1; e >= 0; e--) begin
			if (hit[e]) key = {src_q[e], 9'(rank_q[e]) + 9'd1};
		end
	end
endmodule

FILE: hdl/ipv6_destination_policy_sort.sv
// Top level of the IPv6 destination policy sorter.
// Depends on ipds_pkg, ipds_classify and ipds_cell.
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// request  | start in, busy out   | operation, address, scope, entry fields
// result   | valid out (strobe)   | out_address_*, out_scope_id, precedence...
//
// An entry write or a non-last address leaves busy low; the address is
// classified against the table on acceptance and inserted into the cell row
// in sorted position in that same edge. After a last address the row drains
// one result at a time, shifting toward cell 0. busy holds during emission.
// Reset clears the table valid bits, the row and the counts.
// The receiver cannot stall: each result shows for exactly one cycle.
module ipv6_destination_policy_sort #(
	parameter int POLICY_ENTRIES = 8,
	parameter int LIST_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic operation,
	input  logic [63:0] address_high,
	input  logic [63:0] address_low,
	input  logic [15:0] scope_id,
	input  logic [2:0] entry_index,
	input  logic [4:0] prefix_bytes,
	input  logic [7:0] entry_precedence,
	input  logic has_source,
	input  logic entry_enable,
	input  logic last,
	output logic valid,
	output logic [63:0] out_address_high,
	output logic [63:0] out_address_low,
	output logic [15:0] out_scope_id,
	output logic signed [8:0] out_precedence,
	output logic list_overflow,
	output logic out_last
);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic accept, load, room, ins, shift;
	logic [CW-1:0] count_q;
	logic ovf_q, emit_q;
	logic [ipds_pkg::KEY_W-1:0] key;
	ipds_pkg::item_t new_item;
	logic [LIST_DEPTH:0] cv;
	logic [LIST_DEPTH-1:0] cl;
	ipds_pkg::item_t ci [LIST_DEPTH+1];

	assign accept = start && !busy;
	assign load = accept && operation == ipds_pkg::OP_ADDR;
	assign room = count_q < CW'(LIST_DEPTH);
	assign ins = load && room;
	assign busy = emit_q;
	assign shift = emit_q;

	ipds_classify #(.POLICY_ENTRIES(POLICY_ENTRIES)) u_cls (
		.clk, .arst_n,
		.wr(accept && operation == ipds_pkg::OP_ENTRY && 32'(entry_index) < POLICY_ENTRIES),
		.wr_index(entry_index), .hi(address_high), .lo(address_low),
		.scope(scope_id), .nbytes(prefix_bytes), .rank(entry_precedence),
		.src(has_source), .en(entry_enable), .key(key)
	);

	assign new_item = '{hi: address_high, lo: address_low, scope: scope_id, key: key};

	// tail of the row feeds empties; the head always sees an occupied predecessor
	assign cv[LIST_DEPTH] = 1'b0;
	assign ci[LIST_DEPTH] = new_item;

	genvar g;
	for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
		ipds_cell u_cell (
			.clk, .arst_n, .clear(1'b0), .ins(ins), .new_item(new_item),
			.prev_valid(g == 0 ? 1'b1 : cv[g == 0 ? 0 : g-1]),
			.prev_lower(g == 0 ? 1'b0 : cl[g == 0 ? 0 : g-1]),
			.prev_item(ci[g == 0 ? 0 : g-1]),
			.shift_out(shift), .next_valid(cv[g+1]), .next_item(ci[g+1]),
			.valid(cv[g]), .lower(cl[g]), .item(ci[g])
		);
	end

	// emit from the head while the row drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			emit_q <= 1'b0;
			valid <= 1'b0;
			out_last <= 1'b0;
			list_overflow <= 1'b0;
		end else begin
			valid <= 1'b0;
			out_last <= 1'b0;
			if (emit_q) begin
				valid <= 1'b1;
				list_overflow <= ovf_q;
				out_last <= (count_q == CW'(1));
				count_q <= count_q - CW'(1);
				if (count_q == CW'(1)) begin
					emit_q <= 1'b0;
					ovf_q <= 1'b0;
				end
			end else if (load) begin
				if (ins) count_q <= count_q + CW'(1);
				else ovf_q <= 1'b1;
				if (last) begin
					if (count_q != '0 || ins) begin
						emit_q <= 1'b1;
					end else begin
						ovf_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_q) begin
			out_address_high <= ci[0].hi;
			out_address_low <= ci[0].lo;
			out_scope_id <= ci[0].scope;
			out_precedence <= ci[0].key[8:0] - 9'd1;
		end
	end
endmodule

FILE: test/ipds_checker.sv
// Checker for the IPv6 destination policy sorter: watches the request and result ports,
// predicts the sorted destination lists and compares them. Depends on ipds_pkg.
module ipds_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic operation,
	input  logic [63:0] address_high,
	input  logic [63:0] address_low,
	input  logic [15:0] scope_id,
	input  logic [2:0] entry_index,
	input  logic [4:0] prefix_bytes,
	input  logic [7:0] entry_precedence,
	input  logic has_source,
	input  logic entry_enable,
	input  logic last,
	input  logic valid,
	input  logic [63:0] out_address_high,
	input  logic [63:0] out_address_low,
	input  logic [15:0] out_scope_id,
	input  logic signed [8:0] out_precedence,
	input  logic list_overflow,
	input  logic out_last,
	output int failures,
	output int pending,
	output int sorted_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [15:0] scope;
		logic [8:0] prec;
		logic ovf;
		logic fin;
	} sorted_t;

	logic [63:0] pol_hi [8];
	logic [63:0] pol_lo [8];
	logic [15:0] pol_scope [8];
	logic [4:0] pol_bytes [8];
	logic [7:0] pol_rank [8];
	logic pol_src [8];
	logic pol_on [8];
	ipds_pkg::item_t held [$];
	logic held_ovf;
	sorted_t sorted_q [$];

	assign pending = sorted_q.size();

	function automatic logic [9:0] rank_key(logic [63:0] h, logic [63:0] l, logic [15:0] s);
		logic [127:0] m;
		for (int e = 0; e < 8; e++) begin
			if (!pol_on[e]) continue;
			m = '0;
			for (int b = 0; b < 16; b++)
				if (b < pol_bytes[e]) m[127-8*b -: 8] = 8'hff;
			if ((({h, l} ^ {pol_hi[e], pol_lo[e]}) & m) == '0 && s == pol_scope[e])
				return {pol_src[e], 9'(pol_rank[e]) + 9'd1};
		end
		return '0;
	endfunction

	task automatic emit_sorted();
		ipds_pkg::item_t ord [$];
		int j;
		sorted_t r;
		foreach (held[i]) begin
			j = ord.size();
			while (j > 0 && ord[j-1].key < held[i].key) j--;
			ord.insert(j, held[i]);
		end
		foreach (ord[i]) begin
			r.hi = ord[i].hi;
			r.lo = ord[i].lo;
			r.scope = ord[i].scope;
			r.prec = ord[i].key[8:0] - 9'd1;
			r.ovf = held_ovf;
			r.fin = (i == ord.size() - 1);
			sorted_q.push_back(r);
		end
		held.delete();
		held_ovf = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_t x;
		if (!arst_n) begin
			for (int e = 0; e < 8; e++) pol_on[e] = 0;
			held.delete();
			held_ovf = 0;
			sorted_q.delete();
			failures = 0;
			sorted_seen = 0;
		end else begin
			// results first: a request accepted now cannot produce one this edge
			if (valid) begin
				sorted_seen++;
				if (sorted_q.size() == 0) begin
					failures++;
					if (failures <= 10) $display("unexpected result %h %h", out_address_high, out_address_low);
				end else begin
					x = sorted_q.pop_front();
					if (x != {out_address_high, out_address_low, out_scope_id, out_precedence,
							list_overflow, out_last}) begin
						failures++;
						if (failures <= 10)
							$display("mismatch exp %h/%h/%h/%h/%b/%b got %h/%h/%h/%h/%b/%b",
								x.hi, x.lo, x.scope, x.prec, x.ovf, x.fin,
								out_address_high, out_address_low, out_scope_id,
								out_precedence, list_overflow, out_last);
					end
				end
			end
			if (start && !busy) begin
				if (operation == ipds_pkg::OP_ENTRY) begin
					pol_hi[entry_index] = address_high;
					pol_lo[entry_index] = address_low;
					pol_scope[entry_index] = scope_id;
					pol_bytes[entry_index] = prefix_bytes > ipds_pkg::MAX_BYTES ?
						ipds_pkg::MAX_BYTES : prefix_bytes;
					pol_rank[entry_index] = entry_precedence;
					pol_src[entry_index] = has_source;
					pol_on[entry_index] = entry_enable;
				end else begin
					if (held.size() < 16)
						held.push_back({address_high, address_low, scope_id,
							rank_key(address_high, address_low, scope_id)});
					else
						held_ovf = 1;
					if (last) emit_sorted();
				end
			end
		end
	end
endmodule

FILE: test/ipv6_destination_policy_sort_test.sv
// Top of the policy sorter testbench: clock, reset, request stimulus and verdict.
// Depends on ipds_pkg, ipds_checker and the sorter RTL.
module ipv6_destination_policy_sort_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0, start = 0, busy, operation = 0;
	logic [63:0] address_high = 0, address_low = 0;
	logic [15:0] scope_id = 0;
	logic [2:0] entry_index = 0;
	logic [4:0] prefix_bytes = 0;
	logic [7:0] entry_precedence = 0;
	logic has_source = 0, entry_enable = 0, last = 0;
	logic valid, list_overflow, out_last;
	logic [63:0] out_address_high, out_address_low;
	logic [15:0] out_scope_id;
	logic signed [8:0] out_precedence;
	int failures, pending, sorted_seen, cycles = 0;
	int requests = 0;

	// Addresses drawn near the table's prefixes so that entries actually match.
	logic [63:0] pool_hi [4];
	logic [63:0] pool_lo [4];
	logic [15:0] pool_scope [4];

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	ipv6_destination_policy_sort DUT (.*);
	ipds_checker u_check (.*);

	// Guard against a hung block.
	always @(posedge clk) begin
		cycles++;
		if (cycles > 200000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Hold one request on the ports until it is accepted, after a random gap.
	// start drops only for a gap, so back-to-back requests keep it high.
	task automatic send(logic op, logic [63:0] h, logic [63:0] l, logic [15:0] s,
			logic [2:0] idx, logic [4:0] nb, logic [7:0] pr, logic src, logic en,
			logic lst, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		operation <= op;
		address_high <= h;
		address_low <= l;
		scope_id <= s;
		entry_index <= idx;
		prefix_bytes <= nb;
		entry_precedence <= pr;
		has_source <= src;
		entry_enable <= en;
		last <= lst;
		do @(posedge clk); while (busy);
		requests++;
	endtask

	task automatic random_entry();
		int p;
		p = $urandom_range(0, 3);
		send(ipds_pkg::OP_ENTRY,
			pool_hi[p] ^ ($urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0),
			pool_lo[p], $urandom_range(0, 4) ? pool_scope[p] : 16'($urandom),
			3'($urandom), 5'($urandom_range(0, 31)), 8'($urandom), 1'($urandom),
			$urandom_range(0, 4) != 0, 1'($urandom));
	endtask

	task automatic random_address(logic lst);
		int p;
		p = $urandom_range(0, 3);
		if ($urandom_range(0, 5) == 0)
			send(ipds_pkg::OP_ADDR, {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
				3'($urandom), 5'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), lst);
		else
			send(ipds_pkg::OP_ADDR,
				pool_hi[p] ^ (64'($urandom_range(0, 255)) << (8 * $urandom_range(0, 7))),
				pool_lo[p] ^ 64'($urandom_range(0, 3)), pool_scope[p],
				3'($urandom), 5'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), lst);
	endtask

	initial begin
		int len;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int p = 0; p < 4; p++) begin
			pool_hi[p] = {$urandom, $urandom};
			pool_lo[p] = {$urandom, $urandom};
			pool_scope[p] = p;
		end

		// Directed: empty table, then extremes, then a mid-list table change.
		send(ipds_pkg::OP_ADDR, '1, '1, '1, 0, 0, 0, 0, 0, 1);
		send(ipds_pkg::OP_ENTRY, '1, '1, '1, 3'd7, 5'd31, 8'd255, 1, 1, 1);
		send(ipds_pkg::OP_ENTRY, '0, '0, '0, 3'd0, 5'd0, 8'd0, 0, 1, 0);
		send(ipds_pkg::OP_ENTRY, 64'h2001_0db8_0000_0000, '0, 16'd1, 3'd1, 5'd4, 8'd40,
			1, 1, 0);
		send(ipds_pkg::OP_ADDR, '0, '0, '0, 0, 0, 0, 0, 0, 0);
		send(ipds_pkg::OP_ADDR, '1, '1, '1, 0, 0, 0, 0, 0, 0);
		send(ipds_pkg::OP_ADDR, 64'h2001_0db8_1234_0000, 64'd5, 16'd1, 0, 0, 0, 0, 0, 0);
		send(ipds_pkg::OP_ADDR, '1, 64'hffff_ffff_ffff_fffe, '1, 0, 0, 0, 0, 0, 0);
		send(ipds_pkg::OP_ENTRY, '0, '0, '0, 3'd0, 5'd0, 8'd0, 0, 0, 0);
		send(ipds_pkg::OP_ADDR, 64'h2001_0db8_ffff_0000, 64'd9, 16'd1, 0, 0, 0, 0, 0, 1);
		// Overflow: seventeen addresses, the extra one marked last.
		for (int i = 0; i < 17; i++)
			send(ipds_pkg::OP_ADDR, 64'(i), 64'(i), 16'd1, 0, 0, 0, 0, 0, i == 16);
		for (int e = 0; e < 8; e++)
			send(ipds_pkg::OP_ENTRY, '0, '0, '0, 3'(e), 5'd0, 8'd0, 0, 0, 0);

		// Hold off until the directed lists have drained.
		start <= 0;
		wait (pending == 0);
		@(posedge clk);

		// Random lists of mostly short length, table rewritten in between.
		while (requests < 360) begin
			repeat ($urandom_range(0, 3)) random_entry();
			len = $urandom_range(0, 9) == 0 ? $urandom_range(14, 20) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) random_entry();
				random_address(i == len - 1);
			end
		end

		start <= 0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("Sent %0d requests; checked %0d sorted results including overflow runs.",
			requests, sorted_seen);
		if (failures == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

FILE: ipv6_destination_policy_sort.f
hdl/ipds_pkg.sv
hdl/ipds_cell.sv
hdl/ipds_classify.sv
hdl/ipv6_destination_policy_sort.sv
test/ipds_checker.sv
test/ipv6_destination_policy_sort_test.sv
